[hdl/tgc_pkg.sv]
// ----------------------------------------------------------------------------
// tgc_pkg: touch gesture classifier shared types
// Command, gesture and register index codes plus the register reset values.
// ----------------------------------------------------------------------------
package tgc_pkg;

  // width of every configuration register
  localparam int unsigned CFG_W = 16;

  // register reset values
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd600;
  localparam logic [CFG_W-1:0] SWIPE_MAX_RST  = 16'd400;
  localparam logic [CFG_W-1:0] TAP_RADIUS_RST = 16'd2621;  // 0.04 in Q0.16

  // touch event commands
  typedef enum logic [1:0] {
    CMD_DOWN   = 2'd0,
    CMD_MOTION = 2'd1,
    CMD_UP     = 2'd2,
    CMD_POLL   = 2'd3
  } cmd_e;

  // reported gestures
  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_TAP   = 3'd1,
    GEST_RIGHT = 3'd2,
    GEST_LEFT  = 3'd3,
    GEST_UP    = 3'd4,
    GEST_DOWN  = 3'd5,
    GEST_LONG  = 3'd6
  } gesture_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_SWIPE_MAX  = 2'd1,
    REG_TAP_RADIUS = 2'd2
  } reg_idx_e;

endpackage

[hdl/touch_gesture_classifier_top.sv]
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top: single-finger tap / swipe / long press
// Tracks one touch and reports one gesture code per touch event.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  event   | in        | in_valid_i / in_stall_o   | cmd_i, pos_x_i, pos_y_i, now_ms_i
//  result  | out       | out_valid_o / out_stall_i | gesture_o
//  config  | in        | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
//  one transfer per cycle while out_stall_i is low; an event passes through the event
//  register, then classify logic into the result register
//  the classify stage squares both coordinate offsets and the tap radius, plus add and compare
//  reset clears the touch and long press flags; registers go to their defaults
//  a stalled result register holds; the event register still takes one event,
//  and in_stall_o rises only when both registers are full and out_stall_i is high
// ----------------------------------------------------------------------------
module touch_gesture_classifier_top
  import tgc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  // event channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            cmd_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [TIME_BITS-1:0]  now_ms_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            gesture_o
);

  localparam int unsigned BOX_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
  localparam int unsigned SQ_W  = 2 * COORD_BITS + 1;
  localparam int unsigned CMP_W = (SQ_W > 2 * CFG_W) ? SQ_W : 2 * CFG_W;

  // configuration registers
  logic [CFG_W-1:0] long_press_q, swipe_max_q, tap_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RST;
      swipe_max_q  <= SWIPE_MAX_RST;
      tap_radius_q <= TAP_RADIUS_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        REG_SWIPE_MAX:  swipe_max_q  <= cfg_wdata_i;
        REG_TAP_RADIUS: tap_radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // event register and result register handshake
  logic                  ev_valid_q, ev_valid_d;
  cmd_e                  ev_cmd_q;
  logic [COORD_BITS-1:0] ev_x_q, ev_y_q;
  logic [TIME_BITS-1:0]  ev_ms_q;
  logic                  out_valid_q, out_valid_d;
  gesture_e              gesture_q, gesture_d;
  logic                  res_free, advance, in_take;

  assign res_free   = !out_valid_q || !out_stall_i;
  assign advance    = ev_valid_q && res_free;
  assign in_stall_o = ev_valid_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign ev_valid_d  = in_take || (ev_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ev_cmd_q <= cmd_e'(cmd_i);
      ev_x_q   <= pos_x_i;
      ev_y_q   <= pos_y_i;
      ev_ms_q  <= now_ms_i;
    end
    if (advance) begin
      gesture_q <= gesture_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

  // touch state
  logic                  touching_q, touching_d;
  logic                  hold_rep_q, hold_rep_d;
  logic [COORD_BITS-1:0] first_x_q, first_y_q, recent_x_q, recent_y_q;
  logic [TIME_BITS-1:0]  first_ms_q, recent_ms_q;

  // displacement from start: motion measures the new point, else the last one
  logic [COORD_BITS-1:0] pt_x, pt_y, ax, ay;
  logic [COORD_BITS:0]   dx, dy;
  logic                  dx_neg, dy_neg;

  assign pt_x   = (ev_cmd_q == CMD_MOTION) ? ev_x_q : recent_x_q;
  assign pt_y   = (ev_cmd_q == CMD_MOTION) ? ev_y_q : recent_y_q;
  assign dx     = {1'b0, pt_x} - {1'b0, first_x_q};
  assign dy     = {1'b0, pt_y} - {1'b0, first_y_q};
  assign dx_neg = dx[COORD_BITS];
  assign dy_neg = dy[COORD_BITS];
  assign ax     = dx_neg ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ay     = dy_neg ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

  // circle test against the tap radius
  logic [2*COORD_BITS-1:0] ax_sq, ay_sq;
  logic [2*CFG_W-1:0]      r_sq;
  logic [CMP_W-1:0]        dist_sq;
  logic                    in_circle, in_box;

  assign ax_sq     = (2*COORD_BITS)'(ax) * (2*COORD_BITS)'(ax);
  assign ay_sq     = (2*COORD_BITS)'(ay) * (2*COORD_BITS)'(ay);
  assign r_sq      = (2*CFG_W)'(tap_radius_q) * (2*CFG_W)'(tap_radius_q);
  assign dist_sq   = CMP_W'(ax_sq) + CMP_W'(ay_sq);
  assign in_circle = dist_sq < CMP_W'(r_sq);

  // box test for a tap
  assign in_box = (BOX_W'(ax) < BOX_W'(tap_radius_q)) &&
                  (BOX_W'(ay) < BOX_W'(tap_radius_q));

  // elapsed time: lift uses the last motion (or down) time, otherwise the event time
  logic [TIME_BITS-1:0] t_end, held;
  logic                 long_hit;
  gesture_e             swipe_dir, lift_gest;

  assign t_end    = (ev_cmd_q == CMD_UP) ? recent_ms_q : ev_ms_q;
  assign held     = t_end - first_ms_q;
  assign long_hit = !hold_rep_q && (held > TIME_BITS'(long_press_q)) && in_circle;

  // swipe direction, dominant axis first
  always_comb begin
    if (ax > ay) begin
      swipe_dir = (!dx_neg && (ax != '0)) ? GEST_RIGHT : GEST_LEFT;
    end else begin
      swipe_dir = dy_neg ? GEST_UP : GEST_DOWN;
    end
  end

  // lift classification
  always_comb begin
    if (hold_rep_q) begin
      lift_gest = GEST_NONE;
    end else if (in_box) begin
      lift_gest = (held < TIME_BITS'(long_press_q)) ? GEST_TAP : GEST_NONE;
    end else if (held < TIME_BITS'(swipe_max_q)) begin
      lift_gest = swipe_dir;
    end else begin
      lift_gest = GEST_NONE;
    end
  end

  // per-command result and flag updates
  always_comb begin
    gesture_d  = GEST_NONE;
    touching_d = touching_q;
    hold_rep_d = hold_rep_q;
    case (ev_cmd_q)
      CMD_DOWN: begin
        touching_d = 1'b1;
        hold_rep_d = 1'b0;
      end
      CMD_MOTION, CMD_POLL: begin
        if (touching_q && long_hit) begin
          gesture_d  = GEST_LONG;
          hold_rep_d = 1'b1;
        end
      end
      CMD_UP: begin
        if (touching_q) begin
          touching_d = 1'b0;
          gesture_d  = lift_gest;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touching_q <= 1'b0;
      hold_rep_q <= 1'b0;
    end else if (advance) begin
      touching_q <= touching_d;
      hold_rep_q <= hold_rep_d;
    end
  end

  // start and last positions and times
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (ev_cmd_q == CMD_DOWN) begin
        first_x_q   <= ev_x_q;
        first_y_q   <= ev_y_q;
        first_ms_q  <= ev_ms_q;
        recent_x_q  <= ev_x_q;
        recent_y_q  <= ev_y_q;
        recent_ms_q <= ev_ms_q;
      end else if (ev_cmd_q == CMD_MOTION && touching_q) begin
        recent_x_q  <= ev_x_q;
        recent_y_q  <= ev_y_q;
        recent_ms_q <= ev_ms_q;
      end
    end
  end

endmodule
